>>> rtl/dsht_pkg.sv
// Shared types and constants for the decimal pair SHA-256 token block.
// Holds the round constants, initial hash words and the register map.
// No dependencies.
`timescale 1ns / 1ps

package dsht_pkg;

    // Working variables a..h of one compression round
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
        logic [31:0] g;
        logic [31:0] h;
    } sha_state_t;

    // Sliding message schedule window, word 0 is the one used next
    typedef logic [15:0][31:0] sched_t;

    // Register map: word index taken from paddr[2]
    localparam logic REG_MODULUS = 1'b0;

    localparam logic [30:0] MODULUS_RESET = 31'd67890;

    localparam logic [7:0] ASCII_MINUS = 8'h2d;
    localparam logic [7:0] PAD_MARK    = 8'h80;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam sha_state_t START_H = '{
        a: 32'h6a09e667, b: 32'hbb67ae85, c: 32'h3c6ef372, d: 32'ha54ff53a,
        e: 32'h510e527f, f: 32'h9b05688c, g: 32'h1f83d9ab, h: 32'h5be0cd19
    };

endpackage

>>> rtl/decimal_sha256_token_mod.sv
// 142 register stages. Throughput: one item per cycle unless a result is held. Pipeline:
// 1 capture, 10 decimal digit stages (one multiply by reciprocal of ten each), format,
// join/pad, 64 SHA-256 rounds, digest add, 64 remainder bit steps. A held result freezes
// every stage; s_ready falls only then.
// Synchronous active-low reset clears all valid bits and loads modulus = 67890.
// Depends on dsht_pkg, dsht_round and dsht_divstep.
`timescale 1ns / 1ps

module decimal_sha256_token_mod (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_first_value,
    input  logic signed [31:0] s_second_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [30:0]        m_token,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import dsht_pkg::*;

    localparam int NDIG = 10;

    // Number of significant decimal digits, at least one
    function automatic logic [3:0] digit_count(input logic [NDIG-1:0][3:0] dig);
        logic [3:0] n;
        n = 4'd1;
        for (int k = 0; k < NDIG; k++) begin
            if (dig[k] != 4'd0) begin
                n = 4'(k + 1);
            end
        end
        return n;
    endfunction

    // Left-aligned ASCII string, zero past its end
    function automatic logic [87:0] fmt_str(input logic neg,
                                            input logic [NDIG-1:0][3:0] dig,
                                            input logic [3:0] nd);
        logic [87:0] s;
        logic [3:0]  q;
        logic [3:0]  idx;
        s = '0;
        for (int p = 0; p < 11; p++) begin
            q = 4'(p) - {3'b000, neg};
            if (neg && p == 0) begin
                s[87 - 8*p -: 8] = ASCII_MINUS;
            end else if (q < nd) begin
                idx = nd - 4'd1 - q;
                s[87 - 8*p -: 8] = {4'h3, dig[idx]};
            end
        end
        return s;
    endfunction

    logic        en;
    logic [30:0] modulus_reg;
    logic        cfg_wr;

    // Advance every stage unless a finished result is held
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MODULUS);
    assign prdata = (paddr[2] == REG_MODULUS) ? {1'b0, modulus_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MODULUS_RESET;
        end else if (cfg_wr) begin
            modulus_reg <= pwdata[30:0];
        end
    end

    // Decimal stages: index 0 is the capture register
    logic                  dv_reg   [0:NDIG];
    logic                  neg1_reg [0:NDIG];
    logic                  neg2_reg [0:NDIG];
    logic [31:0]           mag1_reg [0:NDIG];
    logic [31:0]           mag2_reg [0:NDIG];
    logic [NDIG-1:0][3:0]  dig1_reg [0:NDIG];
    logic [NDIG-1:0][3:0]  dig2_reg [0:NDIG];

    // Capture the transfer as sign and magnitude
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg[0] <= s_first_value[31];
            neg2_reg[0] <= s_second_value[31];
            mag1_reg[0] <= s_first_value[31] ? (~s_first_value + 32'd1) : s_first_value;
            mag2_reg[0] <= s_second_value[31] ? (~s_second_value + 32'd1) : s_second_value;
            dig1_reg[0] <= '0;
            dig2_reg[0] <= '0;
        end
    end

    // Peel one digit per stage: quotient by ten through reciprocal multiply
    for (genvar k = 1; k <= NDIG; k++) begin : g_dec
        logic [63:0]          prod1;
        logic [63:0]          prod2;
        logic [31:0]          quo1;
        logic [31:0]          quo2;
        logic [31:0]          rem1;
        logic [31:0]          rem2;
        logic [NDIG-1:0][3:0] dig1_next;
        logic [NDIG-1:0][3:0] dig2_next;

        always_comb begin
            prod1 = 64'(mag1_reg[k-1]) * 64'(32'hcccccccd);
            prod2 = 64'(mag2_reg[k-1]) * 64'(32'hcccccccd);
            quo1  = {3'b000, prod1[63:35]};
            quo2  = {3'b000, prod2[63:35]};
            rem1  = mag1_reg[k-1] - ({quo1[28:0], 3'b000} + {quo1[30:0], 1'b0});
            rem2  = mag2_reg[k-1] - ({quo2[28:0], 3'b000} + {quo2[30:0], 1'b0});
            dig1_next      = dig1_reg[k-1];
            dig2_next      = dig2_reg[k-1];
            dig1_next[k-1] = rem1[3:0];
            dig2_next[k-1] = rem2[3:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k] <= 1'b0;
            end else if (en) begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                neg1_reg[k] <= neg1_reg[k-1];
                neg2_reg[k] <= neg2_reg[k-1];
                mag1_reg[k] <= quo1;
                mag2_reg[k] <= quo2;
                dig1_reg[k] <= dig1_next;
                dig2_reg[k] <= dig2_next;
            end
        end
    end

    // Format stage: strip leading zeros, add sign
    logic        fv_reg;
    logic [87:0] str1_reg;
    logic [87:0] str2_reg;
    logic [3:0]  len1_reg;
    logic [3:0]  len2_reg;
    logic [3:0]  nd1;
    logic [3:0]  nd2;

    assign nd1 = digit_count(dig1_reg[NDIG]);
    assign nd2 = digit_count(dig2_reg[NDIG]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (en) begin
            fv_reg <= dv_reg[NDIG];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            str1_reg <= fmt_str(neg1_reg[NDIG], dig1_reg[NDIG], nd1);
            str2_reg <= fmt_str(neg2_reg[NDIG], dig2_reg[NDIG], nd2);
            len1_reg <= nd1 + {3'b000, neg1_reg[NDIG]};
            len2_reg <= nd2 + {3'b000, neg2_reg[NDIG]};
        end
    end

    // Join stage: concatenate, pad and load the schedule
    logic         jv_reg;
    sched_t       jsched_reg;
    logic [4:0]   msg_len;
    logic [183:0] msg;
    logic [511:0] block;
    sched_t       jsched_next;

    always_comb begin
        msg_len = {1'b0, len1_reg} + {1'b0, len2_reg};
        msg = {str1_reg, 96'b0}
            | ({str2_reg, 96'b0} >> {len1_reg, 3'b000})
            | ({PAD_MARK, 176'b0} >> {msg_len, 3'b000});
        block = {msg, 264'b0, 56'b0, msg_len, 3'b000};
        for (int t = 0; t < 16; t++) begin
            jsched_next[t] = block[511 - 32*t -: 32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jv_reg <= 1'b0;
        end else if (en) begin
            jv_reg <= fv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            jsched_reg <= jsched_next;
        end
    end

    // Compression rounds
    logic       rv    [0:64];
    sha_state_t rstate[0:64];
    sched_t     rsched[0:64];

    assign rv[0]     = jv_reg;
    assign rstate[0] = START_H;
    assign rsched[0] = jsched_reg;

    for (genvar r = 0; r < 64; r++) begin : g_round
        dsht_round #(.ROUND(r)) u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (rv[r]),
            .in_state  (rstate[r]),
            .in_sched  (rsched[r]),
            .out_valid (rv[r+1]),
            .out_state (rstate[r+1]),
            .out_sched (rsched[r+1])
        );
    end

    // Digest prefix: first two hash words
    logic        pv_reg;
    logic [63:0] prefix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else if (en) begin
            pv_reg <= rv[64];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prefix_reg <= {START_H.a + rstate[64].a, START_H.b + rstate[64].b};
        end
    end

    // Remainder, one dividend bit per stage
    logic        qv   [0:64];
    logic [30:0] qrem [0:64];
    logic [63:0] qdvd [0:64];

    assign qv[0]   = pv_reg;
    assign qrem[0] = 31'd0;
    assign qdvd[0] = prefix_reg;

    for (genvar j = 0; j < 64; j++) begin : g_div
        dsht_divstep u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .modulus   (modulus_reg),
            .in_valid  (qv[j]),
            .in_rem    (qrem[j]),
            .in_dvd    (qdvd[j]),
            .out_valid (qv[j+1]),
            .out_rem   (qrem[j+1]),
            .out_dvd   (qdvd[j+1])
        );
    end

    // Last step is the output register; a zero modulus gives zero
    assign m_valid = qv[64];
    assign m_token = (modulus_reg == 31'd0) ? 31'd0 : qrem[64];

endmodule

>>> rtl/dsht_round.sv
// One registered SHA-256 compression round with its schedule step.
// Depends on dsht_pkg for the state types and round constants.
`timescale 1ns / 1ps

module dsht_round #(
    parameter int ROUND = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  dsht_pkg::sha_state_t in_state,
    input  dsht_pkg::sched_t    in_sched,
    output logic                out_valid,
    output dsht_pkg::sha_state_t out_state,
    output dsht_pkg::sched_t    out_sched
);
    import dsht_pkg::*;

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    logic        valid_reg;
    sha_state_t  state_reg;
    sha_state_t  state_next;
    sched_t      sched_reg;
    sched_t      sched_next;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    // Compute the round on word 0 of the window
    always_comb begin
        ch  = (in_state.e & in_state.f) ^ (~in_state.e & in_state.g);
        maj = (in_state.a & in_state.b) ^ (in_state.a & in_state.c)
            ^ (in_state.b & in_state.c);
        t1  = in_state.h + big_sig1(in_state.e) + ch + ROUND_K[ROUND] + in_sched[0];
        t2  = big_sig0(in_state.a) + maj;
        state_next.a = t1 + t2;
        state_next.b = in_state.a;
        state_next.c = in_state.b;
        state_next.d = in_state.c;
        state_next.e = in_state.d + t1;
        state_next.f = in_state.e;
        state_next.g = in_state.f;
        state_next.h = in_state.g;
    end

    // Slide the schedule window and append the next word
    always_comb begin
        for (int k = 0; k < 15; k++) begin
            sched_next[k] = in_sched[k + 1];
        end
        sched_next[15] = in_sched[0] + small_sig0(in_sched[1]) + in_sched[9]
                       + small_sig1(in_sched[14]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            state_reg <= state_next;
            sched_reg <= sched_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_sched = sched_reg;

endmodule

>>> rtl/dsht_divstep.sv
// One registered restoring-division step: brings in one dividend bit
// and subtracts the modulus when the partial remainder reaches it. No package use.
`timescale 1ns / 1ps

module dsht_divstep (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic [30:0] modulus,
    input  logic        in_valid,
    input  logic [30:0] in_rem,
    input  logic [63:0] in_dvd,
    output logic        out_valid,
    output logic [30:0] out_rem,
    output logic [63:0] out_dvd
);
    logic        valid_reg;
    logic [30:0] rem_reg;
    logic [30:0] rem_next;
    logic [63:0] dvd_reg;
    logic [31:0] trial;
    logic [31:0] diff;

    // Shift in the top dividend bit, subtract when not below the modulus
    always_comb begin
        trial    = {in_rem, in_dvd[63]};
        diff     = trial - {1'b0, modulus};
        rem_next = (trial >= {1'b0, modulus}) ? diff[30:0] : trial[30:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            dvd_reg <= {in_dvd[62:0], 1'b0};
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_dvd   = dvd_reg;

endmodule

>>> rtl/dsht_checker.sv
// Port-level checks for decimal_sha256_token_mod, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module dsht_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [30:0] m_token,
    input logic        pready
);
    // Reset empties the pipeline
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A held result keeps its token
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token))
        else $error("held result changed or dropped");

    // Input side never stalls without a waiting result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with output empty");

    // Blocked output stalls the input
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input transfer taken while pipeline frozen");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind decimal_sha256_token_mod dsht_checker u_dsht_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_token (m_token),
    .pready  (pready)
);

>>> verif/decimal_sha256_token_chk.sv
// Checker for decimal_sha256_token_mod: watches the input, result and register ports,
// predicts each token with its own SHA-256 model and compares it with the result.
// Depends on dsht_pkg for the round constants, initial hash and register map.
`timescale 1ns / 1ps

module decimal_sha256_token_chk (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_first_value,
    input  logic signed [31:0] s_second_value,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [30:0]        m_token,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 tokens_waiting,
    output int                 tokens_checked
);
    import dsht_pkg::*;

    logic [30:0] modulus_copy;
    logic [30:0] token_queue[$];

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Format both values as decimal text, hash the padded block, reduce the prefix
    function automatic logic [30:0] hash_token(logic [31:0] first, logic [31:0] second,
                                               logic [30:0] divisor);
        logic [7:0]  blk[64];
        logic [7:0]  digits[10];
        logic [31:0] vals[2];
        logic [31:0] mag;
        logic [31:0] w[64];
        logic [31:0] t1, t2, s0, s1;
        sha_state_t  st;
        logic [63:0] prefix;
        logic [63:0] bitlen;
        int          len, nd;
        vals[0] = first;
        vals[1] = second;
        len = 0;
        for (int i = 0; i < 64; i++) blk[i] = 8'h00;
        for (int v = 0; v < 2; v++) begin
            if (vals[v][31]) begin
                blk[len] = ASCII_MINUS;
                len++;
                mag = ~vals[v] + 32'd1;
            end else begin
                mag = vals[v];
            end
            nd = 0;
            do begin
                digits[nd] = 8'h30 + 8'(mag % 10);
                mag = mag / 10;
                nd++;
            end while (mag != 0 && nd < 10);
            while (nd > 0) begin
                nd--;
                blk[len] = digits[nd];
                len++;
            end
        end
        blk[len] = PAD_MARK;
        bitlen = 64'(len) * 8;
        for (int i = 0; i < 8; i++) blk[63 - i] = bitlen[8*i +: 8];

        // Expand the message schedule
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end

        // Run the 64 compression rounds
        st = START_H;
        for (int i = 0; i < 64; i++) begin
            t1 = st.h + (rotr(st.e, 6) ^ rotr(st.e, 11) ^ rotr(st.e, 25))
                 + ((st.e & st.f) ^ (~st.e & st.g)) + ROUND_K[i] + w[i];
            t2 = (rotr(st.a, 2) ^ rotr(st.a, 13) ^ rotr(st.a, 22))
                 + ((st.a & st.b) ^ (st.a & st.c) ^ (st.b & st.c));
            st.h = st.g; st.g = st.f; st.f = st.e; st.e = st.d + t1;
            st.d = st.c; st.c = st.b; st.b = st.a; st.a = t1 + t2;
        end
        prefix = {START_H.a + st.a, START_H.b + st.b};

        // A zero divisor yields a zero token
        if (divisor == '0)
            return '0;
        return 31'(prefix % {33'd0, divisor});
    endfunction

    assign tokens_waiting = token_queue.size();

    // Track the register, queue predictions on input transfers, check result transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            modulus_copy   <= MODULUS_RESET;
            token_queue.delete();
            fail_count     <= 0;
            tokens_checked <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_MODULUS)
                modulus_copy <= pwdata[30:0];
            if (s_valid && s_ready)
                token_queue.insert(token_queue.size(),
                                   hash_token(s_first_value, s_second_value, modulus_copy));
            if (m_valid && m_ready) begin
                tokens_checked <= tokens_checked + 1;
                if (token_queue.size() == 0) begin
                    $error("token: unexpected result %0d", m_token);
                    fail_count <= fail_count + 1;
                end else if (token_queue[0] !== m_token) begin
                    $error("token: expected %0d, actual %0d", token_queue[0], m_token);
                    fail_count <= fail_count + 1;
                    void'(token_queue.pop_front());
                end else begin
                    void'(token_queue.pop_front());
                end
            end
        end
    end

endmodule

>>> verif/tb_decimal_sha256_token_mod.sv
// Testbench top for decimal_sha256_token_mod: clock, reset, register writes,
// directed and random value pairs with random idling on both sides, and the verdict.
// Depends on dsht_pkg, the block and decimal_sha256_token_chk.
`timescale 1ns / 1ps

module tb_decimal_sha256_token_mod;
    import dsht_pkg::*;

    localparam int LATENCY     = 142;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PAIRS = 1620;

    // Byte addresses: the modulus word and the first word past the map
    localparam logic [2:0] ADDR_MODULUS  = {REG_MODULUS, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_first_value;
    logic signed [31:0] s_second_value;
    logic               m_valid;
    logic               m_ready;
    logic [30:0]        m_token;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int fail_count;
    int tokens_waiting;
    int tokens_checked;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int cycle_count;
    int pairs_sent;
    int modulus_writes;

    decimal_sha256_token_mod u_top (.*);

    decimal_sha256_token_chk u_chk (.*);

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: long hold-off when requested, otherwise random stalls
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("tb_decimal_sha256_token_mod: errors");
                $finish;
            end
        end
    end

    // Offer one pair and hold it until the transfer
    task automatic send_pair(logic [31:0] first, logic [31:0] second);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_first_value  <= first;
        s_second_value <= second;
        do @(posedge aclk); while (!s_ready);
        pairs_sent++;
    endtask

    // Drain all outstanding tokens, then let the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tokens_waiting != 0 || hold_left != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        modulus_writes++;
    endtask

    // Values of every decimal length, both signs, and raw 32-bit patterns
    function automatic logic [31:0] pick_value();
        logic [31:0] mag;
        int          digits;
        if ($urandom_range(3) == 0)
            return $urandom;
        digits = $urandom_range(1, 9);
        mag = $urandom_range(0, 10 ** digits - 1);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    task automatic random_pairs(int count);
        for (int i = 0; i < count; i++)
            send_pair(pick_value(), pick_value());
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_first_value  = '0;
        s_second_value = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_left      = 0;
        pairs_sent     = 0;
        modulus_writes = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pairs under the reset modulus: extremes, signs, digit lengths
        send_pair(32'd0, 32'd0);
        send_pair(32'h8000_0000, 32'h7fff_ffff);
        send_pair(32'h7fff_ffff, 32'h8000_0000);
        send_pair(32'h8000_0000, 32'h8000_0000);
        send_pair(32'hffff_ffff, 32'hffff_ffff);
        send_pair(32'd9, -32'sd10);
        send_pair(32'd1000000000, 32'd999999999);
        send_pair(-32'sd1000000000, 32'd7);
        send_pair(32'h5555_5555, 32'haaaa_aaaa);
        drain();

        // Smallest and largest divisor
        write_reg(ADDR_MODULUS, 32'd1);
        send_pair(32'd12345, -32'sd678);
        send_pair(32'h8000_0000, 32'h7fff_ffff);
        drain();
        write_reg(ADDR_MODULUS, 32'h7fff_ffff);
        send_pair(32'd0, 32'd0);
        send_pair(32'h8000_0000, 32'h7fff_ffff);
        send_pair(-32'sd42, 32'd42);
        drain();

        // Zero divisor gives a zero token
        write_reg(ADDR_MODULUS, 32'd0);
        send_pair(32'd1, 32'd2);
        send_pair(32'hffff_ffff, 32'h8000_0000);
        drain();

        // Upper bit dropped, then a write to an unmapped address left ignored
        write_reg(ADDR_MODULUS, 32'h8001_0009);
        write_reg(ADDR_UNMAPPED, 32'd3);
        send_pair(32'd31337, -32'sd31337);
        send_pair(32'd100, 32'd5);
        drain();

        // Random phase one: sender idles a third, receiver more than half
        write_reg(ADDR_MODULUS, $urandom_range(1, 32'h7fff_ffff));
        send_idle_pct = 33;
        recv_idle_pct = 60;
        random_pairs(RANDOM_PAIRS / 3);
        drain();

        // Random phase two: roles swapped, small divisor
        write_reg(ADDR_MODULUS, $urandom_range(2, 1000));
        send_idle_pct = 60;
        recv_idle_pct = 33;
        random_pairs(RANDOM_PAIRS / 3);
        drain();

        // Random phase three: no idling, long receiver hold-off to fill the pipeline
        write_reg(ADDR_MODULUS, $urandom);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 400;
        random_pairs(RANDOM_PAIRS - 2 * (RANDOM_PAIRS / 3));
        drain();

        $display("covered %0d value pairs, %0d tokens checked, %0d register writes",
                 pairs_sent, tokens_checked, modulus_writes);
        $display("divisors: reset, 1, max, zero, masked, unmapped write, random");
        if (fail_count == 0 && tokens_waiting == 0) begin
            $display("tb_decimal_sha256_token_mod: clean");
        end else begin
            $display("tb_decimal_sha256_token_mod: errors");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/dsht_pkg.sv
rtl/dsht_round.sv
rtl/dsht_divstep.sv
rtl/decimal_sha256_token_mod.sv
rtl/dsht_checker.sv
verif/decimal_sha256_token_chk.sv
verif/tb_decimal_sha256_token_mod.sv
